### rtl/core/gha_pkg.sv
package gha_pkg;

    localparam int SLOT_COUNT    = 1024;
    localparam int VERSION_BITS  = 12;
    localparam int LOCATION_BITS = 32;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int REQ_W = 3;
    localparam int ST_W  = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RELOCATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LOCATE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CONTAINS = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_LIVE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_COUNT);

    // controller -> datapath
    typedef struct packed {
        logic accept;   // request word taken this cycle
        logic pop;      // free stack read data is valid, latch the slot
        logic commit;   // update state and load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_create;
        logic stack_empty;
        logic out_busy;
    } t_sts;

endpackage

### rtl/core/gha_if.sv
interface gha_req_if
    import gha_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [IDX_W-1:0]         handle_index;
    logic [VERSION_BITS-1:0]  handle_version;
    logic [LOCATION_BITS-1:0] new_location;

    modport source (output valid, req_type, handle_index, handle_version, new_location,
                    input ready);
    modport sink   (input valid, req_type, handle_index, handle_version, new_location,
                    output ready);
endinterface

interface gha_rsp_if
    import gha_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_index;
    logic [VERSION_BITS-1:0]  out_version;
    logic [LOCATION_BITS-1:0] out_location;
    logic                     is_live;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         live_count;

    modport source (output valid, out_index, out_version, out_location, is_live, status,
                    live_count, input ready);
    modport sink   (input valid, out_index, out_version, out_location, is_live, status,
                    live_count, output ready);
endinterface

### rtl/core/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/gha_ctrl.sv
module gha_ctrl
    import gha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
                if (i_req_valid) begin
                    // reusing a freed slot needs the stack read before the version read
                    n_state = (i_sts.is_create && !i_sts.stack_empty) ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/gha_dp.sv
module gha_dp
    import gha_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic [IDX_W-1:0]         i_handle_index,
    input  logic [VERSION_BITS-1:0]  i_handle_version,
    input  logic [LOCATION_BITS-1:0] i_new_location,
    gha_rsp_if.source                o_rsp
);

    localparam logic [LOCATION_BITS-1:0] LOC_INVALID = '1;

    // request latched at accept; the slot is reloaded from the free stack at pop
    logic [REQ_W-1:0]         r_req;
    logic [IDX_W-1:0]         r_slot;
    logic [VERSION_BITS-1:0]  r_ver;
    logic [LOCATION_BITS-1:0] r_loc;

    logic [CNT_W-1:0] r_free_top, n_free_top;
    logic [CNT_W-1:0] r_used, n_used;

    // result word
    logic                     r_o_valid, n_o_valid;
    logic [IDX_W-1:0]         r_o_index, n_o_index;
    logic [VERSION_BITS-1:0]  r_o_version, n_o_version;
    logic [LOCATION_BITS-1:0] r_o_location, n_o_location;
    logic                     r_o_live, n_o_live;
    logic [ST_W-1:0]          r_o_status, n_o_status;

    // memory ports
    logic                     ver_we, loc_we, stk_we;
    logic [IDX_W-1:0]         ver_waddr, loc_waddr, ver_raddr, loc_raddr, stk_raddr;
    logic [VERSION_BITS-1:0]  ver_wdata, ver_q;
    logic [LOCATION_BITS-1:0] loc_wdata, loc_q;
    logic [IDX_W-1:0]         stk_q;

    logic                     in_range;
    logic                     live;
    logic                     pop_path;
    logic                     full;
    logic [VERSION_BITS-1:0]  ver_bump;
    logic [IDX_W-1:0]         new_slot;
    logic [VERSION_BITS-1:0]  miss_ver;
    logic [LOCATION_BITS-1:0] miss_loc;

    assign o_sts.is_create   = (i_req_type == REQ_CREATE);
    assign o_sts.stack_empty = (r_free_top == '0);
    assign o_sts.out_busy    = r_o_valid && !o_rsp.ready;

    assign ver_raddr = i_cmd.accept ? i_handle_index : (i_cmd.pop ? stk_q : r_slot);
    assign loc_raddr = i_cmd.accept ? i_handle_index : r_slot;
    assign stk_raddr = IDX_W'(r_free_top - 1'b1);

    gha_ram #(.WIDTH(VERSION_BITS), .DEPTH(SLOT_COUNT)) u_ver_ram (
        .i_clk   (i_clk),
        .i_we    (ver_we),
        .i_waddr (ver_waddr),
        .i_wdata (ver_wdata),
        .i_raddr (ver_raddr),
        .o_rdata (ver_q)
    );

    gha_ram #(.WIDTH(LOCATION_BITS), .DEPTH(SLOT_COUNT)) u_loc_ram (
        .i_clk   (i_clk),
        .i_we    (loc_we),
        .i_waddr (loc_waddr),
        .i_wdata (loc_wdata),
        .i_raddr (loc_raddr),
        .o_rdata (loc_q)
    );

    gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_top[IDX_W-1:0]),
        .i_wdata (r_slot),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    // free_top is unchanged between accept and commit, so it still picks the create path
    assign pop_path = (r_free_top != '0);
    assign full     = !pop_path && (r_used == SLOT_LIMIT);
    assign new_slot = pop_path ? r_slot : r_used[IDX_W-1:0];
    assign in_range = ({{(CNT_W-IDX_W){1'b0}}, r_slot} < r_used);
    assign live     = in_range && (ver_q == r_ver);
    assign ver_bump = VERSION_BITS'(ver_q + 1'b1);
    assign miss_ver = in_range ? ver_q : '0;
    assign miss_loc = in_range ? loc_q : '0;

    always_comb begin
        n_free_top   = r_free_top;
        n_used       = r_used;
        n_o_valid    = (r_o_valid && !o_rsp.ready) ? 1'b1 : 1'b0;
        n_o_index    = r_o_index;
        n_o_version  = r_o_version;
        n_o_location = r_o_location;
        n_o_live     = r_o_live;
        n_o_status   = r_o_status;
        ver_we       = 1'b0;
        ver_waddr    = r_slot;
        ver_wdata    = ver_bump;
        loc_we       = 1'b0;
        loc_waddr    = r_slot;
        loc_wdata    = r_loc;
        stk_we       = 1'b0;

        if (i_cmd.commit) begin
            n_o_valid   = 1'b1;
            n_o_index   = r_slot;
            n_o_version = miss_ver;
            n_o_location = miss_loc;
            n_o_live    = live;
            n_o_status  = ST_OK;
            case (r_req)
                REQ_CREATE: begin
                    if (full) begin
                        n_o_index    = '0;
                        n_o_version  = '0;
                        n_o_location = '0;
                        n_o_live     = 1'b0;
                        n_o_status   = ST_FULL;
                    end else begin
                        loc_we       = 1'b1;
                        loc_waddr    = new_slot;
                        loc_wdata    = LOC_INVALID;
                        n_o_index    = new_slot;
                        n_o_location = LOC_INVALID;
                        n_o_live     = 1'b1;
                        if (pop_path) begin
                            n_free_top  = r_free_top - 1'b1;
                            n_o_version = ver_q;
                        end else begin
                            // fresh slot starts at version zero
                            ver_we      = 1'b1;
                            ver_waddr   = new_slot;
                            ver_wdata   = '0;
                            n_used      = r_used + 1'b1;
                            n_o_version = '0;
                        end
                    end
                end
                REQ_DESTROY: begin
                    if (!live) begin
                        n_o_status = ST_NOT_LIVE;
                    end else if (r_free_top < r_used) begin
                        ver_we      = 1'b1;
                        stk_we      = 1'b1;
                        n_free_top  = r_free_top + 1'b1;
                        n_o_version = ver_bump;
                    end else begin
                        // pushing would drive the live count negative
                        n_o_status = ST_NOT_LIVE;
                    end
                end
                REQ_RELOCATE: begin
                    if (live) begin
                        loc_we       = 1'b1;
                        n_o_location = r_loc;
                    end else begin
                        n_o_status = ST_NOT_LIVE;
                    end
                end
                REQ_LOCATE: begin
                    if (!live) begin
                        n_o_status = ST_NOT_LIVE;
                    end
                end
                default: begin
                    // contains, and unused codes behave the same
                    n_o_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_ver <= i_handle_version;
            r_loc <= i_new_location;
        end
        if (i_cmd.accept) begin
            r_slot <= i_handle_index;
        end else if (i_cmd.pop) begin
            r_slot <= stk_q;
        end
        r_o_index    <= n_o_index;
        r_o_version  <= n_o_version;
        r_o_location <= n_o_location;
        r_o_live     <= n_o_live;
        r_o_status   <= n_o_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_top <= '0;
            r_used     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_free_top <= n_free_top;
            r_used     <= n_used;
            r_o_valid  <= n_o_valid;
        end
    end

    // live count follows the committed state
    logic [CNT_W-1:0] r_o_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_count <= n_used - n_free_top;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.out_index    = r_o_index;
    assign o_rsp.out_version  = r_o_version;
    assign o_rsp.out_location = r_o_location;
    assign o_rsp.is_live      = r_o_live;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.live_count   = r_o_count;

endmodule

### rtl/core/generational_handle_allocator.sv
// Generational handle allocator over a 1024-slot table. Requests (create, destroy, relocate,
// locate, contains) arrive one word at a time on i_req and each gives exactly one result
// word on o_rsp. The result is registered at the commit in S_EXEC after the request is
// accepted; a create that reuses a freed slot first passes through S_POP, since the
// free-stack read must finish before the slot's version can be read. The controller then
// returns to idle to take the next word. The S_POP and S_EXEC steps come from the
// registered read ports of the version, location and free-stack memories. Only one request
// is in flight at a time. A new request is accepted while the previous result still waits
// on o_rsp, and its commit then stalls until that result is taken.
// No clearing pass follows reset: slot and stack memory data are only used where written.
module generational_handle_allocator
    import gha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    gha_req_if.sink   i_req,
    gha_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    gha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gha_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_handle_index   (i_req.handle_index),
        .i_handle_version (i_req.handle_version),
        .i_new_location   (i_req.new_location),
        .o_rsp            (o_rsp)
    );

endmodule
